[hdl/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg: shared types and constants of the integer to ASCII formatter
// Request and result payloads, controller commands and status, digit table.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // digit store geometry (one entry per digit, least significant first)
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;

  // conversion opcodes
  localparam logic [2:0] OP_UDEC = 3'd0;
  localparam logic [2:0] OP_BIN  = 3'd1;
  localparam logic [2:0] OP_OCT  = 3'd2;
  localparam logic [2:0] OP_HEXL = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_SDEC = 3'd5;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_BIN,
    RDX_OCT,
    RDX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DABBLE,
    ST_EXTRACT,
    ST_SIZE,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // one conversion request
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
    logic [6:0]  field_width;
    logic [6:0]  min_digits;
    logic        zero_pad;
    logic        force_plus;
    logic        space_sign;
    logic        alt_prefix;
  } itaf_in_t;

  // one output character
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       empty_res;
  } itaf_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic dabble;
    logic extract;
    logic size;
    logic emit;
    logic empty;
  } itaf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_empty;
    logic is_dec;
    logic dab_done;
    logic ext_done;
    logic emit_last;
  } itaf_stat_t;

  // digit value to ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = 8'h41 + {4'd0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

[hdl/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style integer to ASCII conversion
// One 64-bit integer per request, sent as characters most significant first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the last character has been registered. Characters then come one per
// cycle on out_res with out_valid high, back to back, with last on the final
// one; the receiver must take each in the cycle it is shown. A request goes
// through prepare, then for decimal the shift-and-add-3 BCD conversion, one
// value bit per cycle, then digit extraction, one digit per cycle out of the
// extraction loop, then sizing and emission. A zero value with zero precision
// gives one empty result straight after prepare.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int MAX_CHARS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  itaf_pkg::itaf_in_t  in_req,
  output logic                out_valid,
  output itaf_pkg::itaf_out_t out_res
);

  itaf_pkg::itaf_cmd_t  cmd;
  itaf_pkg::itaf_stat_t stat;

  itaf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  itaf_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

[hdl/itaf_ctrl.sv]
// ----------------------------------------------------------------------------
// itaf_ctrl: sequencing of one conversion
// Prepare, BCD for decimal, digit extraction, sizing and emission, or empty.
// ----------------------------------------------------------------------------
module itaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  itaf_pkg::itaf_stat_t stat,
  output itaf_pkg::itaf_cmd_t  cmd
);

  itaf_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itaf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itaf_pkg::ST_IDLE: begin
        if (start) state_nxt = itaf_pkg::ST_PREP;
      end
      itaf_pkg::ST_PREP: begin
        if (stat.is_empty)    state_nxt = itaf_pkg::ST_EMPTY;
        else if (stat.is_dec) state_nxt = itaf_pkg::ST_DABBLE;
        else                  state_nxt = itaf_pkg::ST_EXTRACT;
      end
      itaf_pkg::ST_DABBLE: begin
        if (stat.dab_done) state_nxt = itaf_pkg::ST_EXTRACT;
      end
      itaf_pkg::ST_EXTRACT: begin
        if (stat.ext_done) state_nxt = itaf_pkg::ST_SIZE;
      end
      itaf_pkg::ST_SIZE: begin
        state_nxt = itaf_pkg::ST_EMIT;
      end
      itaf_pkg::ST_EMIT: begin
        if (stat.emit_last) state_nxt = itaf_pkg::ST_IDLE;
      end
      itaf_pkg::ST_EMPTY: begin
        state_nxt = itaf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = itaf_pkg::ST_IDLE;
      end
    endcase
  end

  // command decode
  always_comb begin
    cmd         = '0;
    busy        = (state_r != itaf_pkg::ST_IDLE);
    cmd.load    = (state_r == itaf_pkg::ST_IDLE) && start;
    cmd.prep    = (state_r == itaf_pkg::ST_PREP);
    cmd.dabble  = (state_r == itaf_pkg::ST_DABBLE);
    cmd.extract = (state_r == itaf_pkg::ST_EXTRACT);
    cmd.size    = (state_r == itaf_pkg::ST_SIZE);
    cmd.emit    = (state_r == itaf_pkg::ST_EMIT);
    cmd.empty   = (state_r == itaf_pkg::ST_EMPTY);
  end

endmodule

[hdl/itaf_datapath.sv]
// ----------------------------------------------------------------------------
// itaf_datapath: prefix, digit generation, digit store and character output
// Decimal goes through a shift-and-add-3 BCD conversion; every radix then
// yields its digits low first into the store, which is read back high first.
// ----------------------------------------------------------------------------
module itaf_datapath #(
  parameter int MAX_CHARS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itaf_pkg::itaf_in_t   in_req,
  input  itaf_pkg::itaf_cmd_t  cmd,
  output itaf_pkg::itaf_stat_t stat,
  output logic                 out_valid,
  output itaf_pkg::itaf_out_t  out_res
);

  localparam int CW   = $clog2(MAX_CHARS + 1);
  localparam int SW   = (CW > 7) ? CW : 7;
  localparam int AW   = itaf_pkg::STORE_AW;
  localparam int NDW  = AW + 1;

  // request and per-item setup
  itaf_pkg::itaf_in_t req_r;
  itaf_pkg::radix_t   radix_r, radix_nxt;
  logic               upper_r, upper_nxt;
  logic [1:0]         npre_r, npre_nxt;
  logic [7:0]         pre0_r, pre0_nxt, pre1_r, pre1_nxt;
  logic [6:0]         minlen_r, minlen_nxt;
  logic [63:0]        mag;
  logic [2:0]         op_eff;

  // digit generation
  logic [63:0]        bin_r;
  logic [79:0]        work_r;
  logic [79:0]        work_adj, work_shift;
  logic [AW-1:0]      step_r;
  logic [NDW-1:0]     ndig_r;
  logic [3:0]         dig;

  // store
  logic [7:0]         mem [itaf_pkg::STORE_DEPTH];
  logic [7:0]         rd_data_r;
  logic [AW-1:0]      dptr_r, dptr_nxt;

  // sizing
  logic [SW-1:0]      ndig_w, minlen_w, npre_w, nzero, budget, keepdig, room, keepzero;
  logic [CW-1:0]      zero_end_r, total_r, k_r, k_inc;

  // output
  logic               out_valid_r;
  itaf_pkg::itaf_out_t out_res_r;
  logic [7:0]         emit_char;

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
  end

  // status to controller
  assign op_eff = (req_r.opcode > itaf_pkg::OP_SDEC) ? itaf_pkg::OP_UDEC : req_r.opcode;
  assign stat.is_empty = (req_r.value == 64'd0) && (req_r.min_digits == 7'd0);
  assign stat.is_dec   = (op_eff == itaf_pkg::OP_UDEC) || (op_eff == itaf_pkg::OP_SDEC);
  assign stat.dab_done = (step_r == {AW{1'b1}});

  // prefix, radix and minimum length
  always_comb begin
    logic [6:0] wr;
    radix_nxt = itaf_pkg::RDX_DEC;
    upper_nxt = 1'b0;
    npre_nxt  = 2'd0;
    pre0_nxt  = itaf_pkg::CH_ZERO;
    pre1_nxt  = itaf_pkg::CH_LX;
    mag       = req_r.value;
    case (op_eff)
      itaf_pkg::OP_BIN: begin
        radix_nxt = itaf_pkg::RDX_BIN;
      end
      itaf_pkg::OP_OCT: begin
        radix_nxt = itaf_pkg::RDX_OCT;
        if (req_r.alt_prefix) npre_nxt = 2'd1;
      end
      itaf_pkg::OP_HEXL, itaf_pkg::OP_HEXU: begin
        radix_nxt = itaf_pkg::RDX_HEX;
        upper_nxt = (op_eff == itaf_pkg::OP_HEXU);
        if (upper_nxt) pre1_nxt = itaf_pkg::CH_UX;
        if (req_r.alt_prefix) npre_nxt = 2'd2;
      end
      itaf_pkg::OP_SDEC: begin
        if (req_r.value[63]) begin
          npre_nxt = 2'd1;
          pre0_nxt = itaf_pkg::CH_MINUS;
          mag      = ~req_r.value + 64'd1;
        end else if (req_r.space_sign) begin
          npre_nxt = 2'd1;
          pre0_nxt = itaf_pkg::CH_SPACE;
        end else if (req_r.force_plus) begin
          npre_nxt = 2'd1;
          pre0_nxt = itaf_pkg::CH_PLUS;
        end
      end
      default: begin
        radix_nxt = itaf_pkg::RDX_DEC;
      end
    endcase
    wr = (req_r.field_width > {5'd0, npre_nxt}) ? req_r.field_width - {5'd0, npre_nxt}
                                                 : 7'd0;
    if (req_r.zero_pad && (wr > req_r.min_digits)) minlen_nxt = wr;
    else                                            minlen_nxt = req_r.min_digits;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      radix_r  <= radix_nxt;
      upper_r  <= upper_nxt;
      npre_r   <= npre_nxt;
      pre0_r   <= pre0_nxt;
      pre1_r   <= pre1_nxt;
      minlen_r <= minlen_nxt;
    end
  end

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 20; i++) begin
      work_adj[i*4 +: 4] = (work_r[i*4 +: 4] >= 4'd5) ? work_r[i*4 +: 4] + 4'd3
                                                      : work_r[i*4 +: 4];
    end
  end

  // low digit and the remainder after it
  always_comb begin
    case (radix_r)
      itaf_pkg::RDX_BIN: begin
        dig        = {3'd0, work_r[0]};
        work_shift = work_r >> 1;
      end
      itaf_pkg::RDX_OCT: begin
        dig        = {1'b0, work_r[2:0]};
        work_shift = work_r >> 3;
      end
      default: begin
        dig        = work_r[3:0];
        work_shift = work_r >> 4;
      end
    endcase
  end

  assign stat.ext_done = (work_shift == 80'd0) ||
                         (ndig_r == NDW'(itaf_pkg::STORE_DEPTH - 1));

  // value, BCD and digit-count registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      bin_r  <= mag;
      work_r <= stat.is_dec ? 80'd0 : {16'd0, mag};
      step_r <= '0;
      ndig_r <= '0;
    end else if (cmd.dabble) begin
      work_r <= {work_adj[78:0], bin_r[63]};
      bin_r  <= {bin_r[62:0], 1'b0};
      step_r <= step_r + AW'(1);
    end else if (cmd.extract) begin
      work_r <= work_shift;
      ndig_r <= ndig_r + NDW'(1);
    end
  end

  // digit store write
  always_ff @(posedge clk) begin
    if (cmd.extract) mem[ndig_r[AW-1:0]] <= itaf_pkg::digit_char(dig, upper_r);
  end

  // leading zeros and cap
  always_comb begin
    ndig_w   = SW'(ndig_r);
    minlen_w = SW'(minlen_r);
    npre_w   = SW'(npre_r);
    nzero    = (minlen_w > ndig_w) ? minlen_w - ndig_w : '0;
    budget   = SW'(MAX_CHARS) - npre_w;
    keepdig  = (ndig_w < budget) ? ndig_w : budget;
    room     = budget - keepdig;
    keepzero = (nzero < room) ? nzero : room;
  end

  // read pointer steps down through the kept digits
  always_comb begin
    dptr_nxt = dptr_r;
    if (cmd.size) begin
      dptr_nxt = AW'(keepdig - SW'(1));
    end else if (cmd.emit && (k_r >= zero_end_r)) begin
      dptr_nxt = dptr_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    dptr_r    <= dptr_nxt;
    rd_data_r <= mem[dptr_nxt];
  end

  // emission counters
  assign k_inc          = k_r + CW'(1);
  assign stat.emit_last = (k_inc == total_r);

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      zero_end_r <= CW'(npre_w + keepzero);
      total_r    <= CW'(npre_w + keepzero + keepdig);
      k_r        <= '0;
    end else if (cmd.emit) begin
      k_r <= k_inc;
    end
  end

  // character for the current position
  always_comb begin
    if (k_r < CW'(npre_r))   emit_char = k_r[0] ? pre1_r : pre0_r;
    else if (k_r < zero_end_r) emit_char = itaf_pkg::CH_ZERO;
    else                     emit_char = rd_data_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.empty) begin
      out_res_r.out_char  <= itaf_pkg::CH_NUL;
      out_res_r.last      <= 1'b1;
      out_res_r.empty_res <= 1'b1;
    end else if (cmd.emit) begin
      out_res_r.out_char  <= emit_char;
      out_res_r.last      <= stat.emit_last;
      out_res_r.empty_res <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[hdl/itaf_checker.sv]
// ----------------------------------------------------------------------------
// itaf_checker: port-level checks of the integer to ASCII formatter
// Watches request acceptance and the shape of each character burst.
// ----------------------------------------------------------------------------
module itaf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input itaf_pkg::itaf_out_t out_res
);

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after an accepted request");

  // an empty conversion is a single null character
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.empty_res |-> out_res.last && (out_res.out_char == 8'h00))
    else $error("malformed empty result");

  // characters of one conversion come without gaps
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |=> out_valid)
    else $error("gap inside a character burst");

  // the next conversion cannot follow its predecessor directly
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |=> !out_valid)
    else $error("character right after last");

  // nothing comes out while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid)
    else $error("output while idle");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
